FILE: sv/atte_pkg.sv
`default_nettype none
package atte_pkg;

    localparam int NUM_BUCKETS  = 4;
    localparam int NUM_CHANNELS = 2;
    localparam int NUM_SLOTS    = NUM_CHANNELS * NUM_BUCKETS;
    localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [39:0] LIMIT_ONE_RST   = 40'd4096;
    localparam logic [39:0] LIMIT_TWO_RST   = 40'd65536;
    localparam logic [39:0] LIMIT_THREE_RST = 40'd1048576;

    localparam logic [19:0] QUEUE_SEED  = 20'd50000;
    localparam logic [19:0] QUEUE_MIN   = 20'd6250;
    localparam logic [19:0] QUEUE_MAX   = 20'd800000;
    localparam logic [39:0] START_SEED  = 40'd200000;
    localparam logic [20:0] COST_SEED   = 21'd131072;
    localparam logic [20:0] DUAL_SEED   = 21'd163840;
    localparam logic [20:0] COST_MIN    = 21'd16384;
    localparam logic [20:0] COST_MAX    = 21'd1048576;
    localparam logic [8:0]  SLOW_SEED   = 9'd125;
    localparam logic [8:0]  SLOW_MIN    = 9'd100;
    localparam logic [8:0]  SLOW_MAX    = 9'd400;

    // divide by 100: 2^32 = 100 * PCT_HI_MUL + 96, low part by reciprocal of 25 >> 37
    localparam logic [63:0] PCT_RECIP  = 64'd5497558139;
    localparam logic [63:0] PCT_HI_MUL = 64'd42949672;

    localparam logic [6:0] COST_MUL_STEPS = 7'd21;
    localparam logic [6:0] SLOW_MUL_STEPS = 7'd9;
    localparam logic [6:0] PCT_LO_STEPS   = 7'd31;
    localparam logic [6:0] PCT_HI_STEPS   = 7'd19;
    localparam logic [6:0] DIV_STEPS      = 7'd64;

    localparam logic [1:0] REG_LIMIT_ONE   = 2'd0;
    localparam logic [1:0] REG_LIMIT_TWO   = 2'd1;
    localparam logic [1:0] REG_LIMIT_THREE = 2'd2;

    typedef enum logic [1:0] {
        CMD_BEGIN    = 2'd0,
        CMD_MISS     = 2'd1,
        CMD_ESTIMATE = 2'd2,
        CMD_OBSERVE  = 2'd3
    } t_cmd;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_op;

    typedef struct packed {
        logic        start;
        t_op         op;
        logic [6:0]  steps;
        logic [63:0] a;
        logic [63:0] b;
    } t_unit_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] result;
    } t_unit_rsp;

    function automatic logic [39:0] blend(input logic [39:0] v, input logic [39:0] s,
                                          input logic [2:0] c);
        logic [42:0] sum;
        if (c < 3'd4) begin
            sum = ({3'b0, v} + {3'b0, s}) >> 1;
        end else begin
            sum = (({3'b0, v} << 3) - {3'b0, v} + {3'b0, s}) >> 3;
        end
        return sum[39:0];
    endfunction

    function automatic logic [2:0] count_up(input logic [2:0] c);
        return (c < 3'd4) ? c + 3'd1 : c;
    endfunction

endpackage
`default_nettype wire

FILE: sv/atte_unit.sv
`default_nettype none
module atte_unit
    import atte_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_unit_req i_req,
    output t_unit_rsp      o_rsp
);

    logic        r_busy;
    logic        r_done;
    t_op         r_op;
    logic [6:0]  r_cnt;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [63:0] r_rem;

    logic [64:0] trial;
    logic        ge;

    always_comb begin
        trial = {r_rem, r_a[63]};
        ge    = trial >= {1'b0, r_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= i_req.steps;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (r_op == OP_MUL) begin
                    // shift-add, one multiplier bit a cycle
                    if (r_b[0]) begin
                        r_acc <= r_acc + r_a;
                    end
                    r_a <= r_a << 1;
                    r_b <= r_b >> 1;
                end else begin
                    // restoring divide, one quotient bit a cycle
                    r_rem <= ge ? trial[63:0] - r_b : trial[63:0];
                    r_acc <= {r_acc[62:0], ge};
                    r_a   <= r_a << 1;
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule
`default_nettype wire

FILE: sv/adaptive_transfer_time_estimator_top.sv
`default_nettype none
// Transfer time estimator for two channels and four size buckets. Each word on the
// input stream gets one result word holding the queue, execution and total estimates
// computed from the learned state before the word's command is applied. All products
// and quotients run through one shared shift-add / restoring-divide unit, one bit per
// cycle, and the block takes no new word until the previous one is fully applied.
// Estimates need the cost multiply, plus, when both channels have missed, the overlap
// slowdown scaling (its divide by 100 is two reciprocal multiplies); an observe that
// learns a cost adds the cost divide and, on overlap, the slowdown ratio divide.
// A result word held by the receiver stalls the block.
// Configuration writes are always accepted and should be made while idle.
module adaptive_transfer_time_estimator_top
    import atte_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [39:0]  i_cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // byte_count, measured_queue_ns, measured_exec_ns, overlap_active, zero pad
    input  wire logic [127:0] s_tdata,
    // command, channel
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // queue_estimate_ns, exec_estimate_ns, total_estimate_ns, zero pad
    output logic [111:0]      m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COST_WAIT,
        ST_SLOW_WAIT,
        ST_PCT_WAIT,
        ST_HI_WAIT,
        ST_OUT,
        ST_UPDATE,
        ST_LEARN_WAIT,
        ST_RATIO_WAIT
    } t_state;

    t_state      r_state;
    t_unit_req   r_req;
    t_unit_rsp   unit_rsp;

    logic [39:0] r_limit_one, r_limit_two, r_limit_three;

    logic [19:0] r_queue   [NUM_CHANNELS];
    logic [2:0]  r_qcnt    [NUM_CHANNELS];
    logic        r_miss    [NUM_CHANNELS];
    logic [39:0] r_startup [NUM_SLOTS];
    logic [20:0] r_solo    [NUM_SLOTS];
    logic [20:0] r_dualc   [NUM_SLOTS];
    logic [2:0]  r_scnt    [NUM_SLOTS];
    logic [2:0]  r_dcnt    [NUM_SLOTS];
    logic [8:0]  r_slow;
    logic [39:0] r_fabric;
    logic        r_fabric_seen;

    t_cmd        r_cmd;
    logic        r_ch;
    logic [39:0] r_bytes, r_qns, r_ens;
    logic        r_overlap;
    logic [SLOT_W-1:0] r_slot;
    logic        r_dual;
    logic [43:0] r_exec;
    logic [20:0] r_sample;
    logic [18:0] r_pct_hi;

    logic        r_m_valid;
    logic [19:0] r_o_queue;
    logic [42:0] r_o_exec;
    logic [43:0] r_o_total;

    logic [1:0]        bucket;
    logic [SLOT_W-1:0] slot;
    logic [41:0]       exec_sum;
    logic [44:0]       total_sum;
    logic [19:0]       qclamp;
    logic [39:0]       start_v, body;
    logic [63:0]       quot;
    logic [20:0]       sample_c, solo_div;
    logic [27:0]       sample_x100;
    logic [8:0]        ratio;
    logic [11:0]       slow_sum;
    logic [42:0]       fabric_sum;
    logic [18:0]       pct_hi;
    logic [32:0]       pct_b;

    always_comb begin
        if (s_tdata[39:0] >= r_limit_three) begin
            bucket = 2'd3;
        end else if (s_tdata[39:0] >= r_limit_two) begin
            bucket = 2'd2;
        end else if (s_tdata[39:0] >= r_limit_one) begin
            bucket = 2'd1;
        end else begin
            bucket = 2'd0;
        end
        if (int'(bucket) > NUM_BUCKETS - 1) begin
            slot = SLOT_W'(int'(s_tuser[2]) * NUM_BUCKETS + NUM_BUCKETS - 1);
        end else begin
            slot = SLOT_W'(int'(s_tuser[2]) * NUM_BUCKETS + int'(bucket));
        end

        exec_sum  = {2'b0, r_startup[r_slot]} + {1'b0, unit_rsp.result[60:20]};
        total_sum = {25'b0, r_queue[r_ch]} + {1'b0, r_exec}
                  + (r_dual ? {5'b0, r_fabric} : 45'd0);

        // high part of the scaled product times 96, plus its low 32 bits
        pct_hi = unit_rsp.result[50:32];
        pct_b  = {8'b0, pct_hi, 6'b0} + {9'b0, pct_hi, 5'b0}
               + {1'b0, unit_rsp.result[31:0]};

        if (r_qns < {20'b0, QUEUE_MIN}) begin
            qclamp = QUEUE_MIN;
        end else if (r_qns > {20'b0, QUEUE_MAX}) begin
            qclamp = QUEUE_MAX;
        end else begin
            qclamp = r_qns[19:0];
        end

        start_v = r_startup[r_slot];
        body    = (r_ens > start_v) ? r_ens - start_v : r_ens >> 1;

        quot = unit_rsp.result;
        if (quot < {43'b0, COST_MIN}) begin
            sample_c = COST_MIN;
        end else if (quot > {43'b0, COST_MAX}) begin
            sample_c = COST_MAX;
        end else begin
            sample_c = quot[20:0];
        end

        sample_x100 = ({7'b0, r_sample} << 6) + ({7'b0, r_sample} << 5)
                    + ({7'b0, r_sample} << 2);
        solo_div    = (r_solo[r_slot] != 21'd0) ? r_solo[r_slot] : COST_SEED;

        if (quot < {55'b0, SLOW_MIN}) begin
            ratio = SLOW_MIN;
        end else if (quot > {55'b0, SLOW_MAX}) begin
            ratio = SLOW_MAX;
        end else begin
            ratio = quot[8:0];
        end
        slow_sum   = (({3'b0, r_slow} << 3) - {3'b0, r_slow} + {3'b0, ratio}) >> 3;
        fabric_sum = (({3'b0, r_fabric} << 3) - {3'b0, r_fabric} + {6'b0, r_ens[39:3]}) >> 3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_req.start   <= 1'b0;
            r_m_valid     <= 1'b0;
            r_limit_one   <= LIMIT_ONE_RST;
            r_limit_two   <= LIMIT_TWO_RST;
            r_limit_three <= LIMIT_THREE_RST;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_queue[i] <= QUEUE_SEED;
                r_qcnt[i]  <= '0;
                r_miss[i]  <= 1'b0;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_startup[i] <= START_SEED;
                r_solo[i]    <= COST_SEED;
                r_dualc[i]   <= DUAL_SEED;
                r_scnt[i]    <= '0;
                r_dcnt[i]    <= '0;
            end
            r_slow        <= SLOW_SEED;
            r_fabric      <= '0;
            r_fabric_seen <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            if (m_tvalid && m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_LIMIT_ONE:   r_limit_one   <= i_cfg_data;
                    REG_LIMIT_TWO:   r_limit_two   <= i_cfg_data;
                    REG_LIMIT_THREE: r_limit_three <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        r_cmd       <= t_cmd'(s_tuser[1:0]);
                        r_ch        <= s_tuser[2];
                        r_bytes     <= s_tdata[39:0];
                        r_qns       <= s_tdata[79:40];
                        r_ens       <= s_tdata[119:80];
                        r_overlap   <= s_tdata[120];
                        r_slot      <= slot;
                        r_dual      <= r_miss[0] && r_miss[1];
                        r_req.start <= 1'b1;
                        r_req.op    <= OP_MUL;
                        r_req.steps <= COST_MUL_STEPS;
                        r_req.a     <= {24'b0, s_tdata[39:0]};
                        r_req.b     <= {43'b0, (r_miss[0] && r_miss[1]) ? r_dualc[slot]
                                                                        : r_solo[slot]};
                        r_state     <= ST_COST_WAIT;
                    end
                end
                ST_COST_WAIT: begin
                    if (unit_rsp.done) begin
                        if (r_dual) begin
                            r_req.start <= 1'b1;
                            r_req.op    <= OP_MUL;
                            r_req.steps <= SLOW_MUL_STEPS;
                            r_req.a     <= {22'b0, exec_sum};
                            r_req.b     <= {55'b0, r_slow};
                            r_state     <= ST_SLOW_WAIT;
                        end else begin
                            r_exec  <= {2'b0, exec_sum};
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_SLOW_WAIT: begin
                    if (unit_rsp.done) begin
                        r_pct_hi    <= pct_hi;
                        r_req.start <= 1'b1;
                        r_req.op    <= OP_MUL;
                        r_req.steps <= PCT_LO_STEPS;
                        r_req.a     <= PCT_RECIP;
                        r_req.b     <= {33'b0, pct_b[32:2]};
                        r_state     <= ST_PCT_WAIT;
                    end
                end
                ST_PCT_WAIT: begin
                    if (unit_rsp.done) begin
                        r_exec      <= {17'b0, unit_rsp.result[63:37]};
                        r_req.start <= 1'b1;
                        r_req.op    <= OP_MUL;
                        r_req.steps <= PCT_HI_STEPS;
                        r_req.a     <= PCT_HI_MUL;
                        r_req.b     <= {45'b0, r_pct_hi};
                        r_state     <= ST_HI_WAIT;
                    end
                end
                ST_HI_WAIT: begin
                    if (unit_rsp.done) begin
                        r_exec  <= r_exec + unit_rsp.result[43:0];
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_m_valid || m_tready) begin
                        r_m_valid <= 1'b1;
                        r_o_queue <= r_queue[r_ch];
                        r_o_exec  <= r_exec[42:0];
                        r_o_total <= total_sum[43:0];
                        r_state   <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    r_state <= ST_IDLE;
                    case (r_cmd)
                        CMD_BEGIN: begin
                            for (int i = 0; i < NUM_CHANNELS; i++) begin
                                r_miss[i] <= 1'b0;
                            end
                        end
                        CMD_MISS: r_miss[r_ch] <= 1'b1;
                        CMD_OBSERVE: begin
                            if (r_qns != 40'd0) begin
                                r_queue[r_ch] <= 20'(blend({20'b0, r_queue[r_ch]},
                                                           {20'b0, qclamp}, r_qcnt[r_ch]));
                                r_qcnt[r_ch]  <= count_up(r_qcnt[r_ch]);
                            end
                            if (r_bytes != 40'd0 && r_ens != 40'd0) begin
                                if (body < (start_v >> 2)) begin
                                    r_startup[r_slot] <= blend(start_v, r_ens, r_scnt[r_slot]);
                                    r_scnt[r_slot]    <= count_up(r_scnt[r_slot]);
                                end else begin
                                    r_req.start <= 1'b1;
                                    r_req.op    <= OP_DIV;
                                    r_req.steps <= DIV_STEPS;
                                    r_req.a     <= {4'b0, body, 20'b0};
                                    r_req.b     <= {24'b0, r_bytes};
                                    r_state     <= ST_LEARN_WAIT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                ST_LEARN_WAIT: begin
                    if (unit_rsp.done) begin
                        r_sample <= sample_c;
                        if (r_overlap) begin
                            r_dualc[r_slot] <= 21'(blend({19'b0, r_dualc[r_slot]},
                                                         {19'b0, sample_c}, r_dcnt[r_slot]));
                            r_dcnt[r_slot]  <= count_up(r_dcnt[r_slot]);
                            r_state         <= ST_RATIO_WAIT;
                        end else begin
                            r_solo[r_slot] <= 21'(blend({19'b0, r_solo[r_slot]},
                                                        {19'b0, sample_c}, r_scnt[r_slot]));
                            r_scnt[r_slot] <= count_up(r_scnt[r_slot]);
                            r_state        <= ST_IDLE;
                        end
                    end
                end
                ST_RATIO_WAIT: begin
                    // ratio divide issued here once the sample is registered
                    if (!unit_rsp.busy && !unit_rsp.done && !r_req.start) begin
                        r_req.start <= 1'b1;
                        r_req.op    <= OP_DIV;
                        r_req.steps <= DIV_STEPS;
                        r_req.a     <= {36'b0, sample_x100};
                        r_req.b     <= {43'b0, solo_div};
                    end
                    if (unit_rsp.done) begin
                        r_slow        <= slow_sum[8:0];
                        r_fabric      <= r_fabric_seen ? fabric_sum[39:0] : {3'b0, r_ens[39:3]};
                        r_fabric_seen <= 1'b1;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    atte_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (unit_rsp)
    );

    assign o_cfg_ready = 1'b1;
    assign s_tready    = (r_state == ST_IDLE);
    assign m_tvalid    = r_m_valid;
    assign m_tdata     = {5'b0, r_o_total, r_o_exec, r_o_queue};

`ifndef SYNTHESIS
    a_idle_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !unit_rsp.busy)
        else $error("shared unit busy while idle");
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unit_rsp.done |-> (r_state == ST_COST_WAIT || r_state == ST_SLOW_WAIT ||
                           r_state == ST_PCT_WAIT || r_state == ST_HI_WAIT ||
                           r_state == ST_LEARN_WAIT || r_state == ST_RATIO_WAIT))
        else $error("unit result with no step waiting");
    a_slow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slow >= SLOW_MIN) && (r_slow <= SLOW_MAX))
        else $error("slowdown out of range");
    a_out_after_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == ST_OUT))
        else $error("result word outside output step");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/adaptive_transfer_time_estimator_top_test.sv
`timescale 1ns / 1ps
module adaptive_transfer_time_estimator_top_test;
    import atte_pkg::*;

    localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;

    typedef struct {
        t_cmd        cmd;
        logic        ch;
        logic [39:0] bytes;
        logic [39:0] qns;
        logic [39:0] ens;
        logic        ovl;
    } t_xfer;

    typedef struct {
        logic [19:0] queue_ns;
        logic [42:0] exec_ns;
        logic [43:0] total_ns;
    } t_estimate;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = REG_LIMIT_ONE;
    logic [39:0]  i_cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;

    adaptive_transfer_time_estimator_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 i_clk = ~i_clk;

    t_xfer     pending_xfers[$];
    t_estimate expected_estimates[$];
    int        errors = 0;
    int        send_idle_pct = 33;
    int        recv_idle_pct = 83;
    int        hold_cycles = 0;
    bit        in_taken = 1'b0;

    // learned state of the predictor
    logic [63:0] lim_one, lim_two, lim_three;
    logic [63:0] q_delay[NUM_CHANNELS];
    int          q_count[NUM_CHANNELS];
    logic [63:0] startup[NUM_SLOTS];
    logic [63:0] solo_cost[NUM_SLOTS];
    logic [63:0] dual_cost[NUM_SLOTS];
    int          solo_count[NUM_SLOTS];
    int          dual_count[NUM_SLOTS];
    bit          missed[NUM_CHANNELS];
    logic [63:0] slowdown_pct;
    logic [63:0] fabric_ns;
    bit          fabric_valid;

    task automatic clear_learning();
        lim_one = LIMIT_ONE_RST;
        lim_two = LIMIT_TWO_RST;
        lim_three = LIMIT_THREE_RST;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            q_delay[i] = QUEUE_SEED;
            q_count[i] = 0;
            missed[i] = 1'b0;
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            startup[i] = START_SEED;
            solo_cost[i] = COST_SEED;
            dual_cost[i] = DUAL_SEED;
            solo_count[i] = 0;
            dual_count[i] = 0;
        end
        slowdown_pct = SLOW_SEED;
        fabric_ns = 0;
        fabric_valid = 1'b0;
    endtask

    task automatic ewma(ref logic [63:0] v, ref int cnt, input logic [63:0] smp);
        if (cnt < 4) begin
            v = (v + smp) / 2;
            cnt++;
        end else begin
            v = (v * 7 + smp) / 8;
        end
    endtask

    task automatic predict_and_learn(input t_xfer x);
        int          slot;
        int          bkt;
        bit          dual;
        logic [63:0] cost, exec_ns, total_ns, qs, start, body, smp, solo, ratio;
        t_estimate   r;
        if (x.bytes >= lim_three) bkt = 3;
        else if (x.bytes >= lim_two) bkt = 2;
        else if (x.bytes >= lim_one) bkt = 1;
        else bkt = 0;
        if (bkt > NUM_BUCKETS - 1) bkt = NUM_BUCKETS - 1;
        slot = x.ch * NUM_BUCKETS + bkt;
        dual = missed[0] && missed[1];
        cost = dual ? dual_cost[slot] : solo_cost[slot];
        exec_ns = startup[slot];
        if (x.bytes != 0) exec_ns += ((64'(x.bytes) * cost) >> 20);
        if (dual) exec_ns = (exec_ns * slowdown_pct) / 100;
        total_ns = q_delay[x.ch] + exec_ns;
        if (dual) total_ns += fabric_ns;
        r.queue_ns = q_delay[x.ch][19:0];
        r.exec_ns = exec_ns[42:0];
        r.total_ns = total_ns[43:0];
        expected_estimates.push_back(r);

        case (x.cmd)
            CMD_BEGIN: begin
                missed[0] = 1'b0;
                missed[1] = 1'b0;
            end
            CMD_MISS: missed[x.ch] = 1'b1;
            CMD_OBSERVE: begin
                if (x.qns != 0) begin
                    qs = x.qns;
                    if (qs < QUEUE_MIN) qs = QUEUE_MIN;
                    if (qs > QUEUE_MAX) qs = QUEUE_MAX;
                    ewma(q_delay[x.ch], q_count[x.ch], qs);
                end
                if (x.bytes != 0 && x.ens != 0) begin
                    start = startup[slot];
                    body = (x.ens > start) ? (x.ens - start) : (x.ens / 2);
                    if (body < start / 4) begin
                        ewma(startup[slot], solo_count[slot], x.ens);
                    end else begin
                        smp = (body << 20) / x.bytes;
                        if (smp < COST_MIN) smp = COST_MIN;
                        if (smp > COST_MAX) smp = COST_MAX;
                        if (x.ovl) begin
                            ewma(dual_cost[slot], dual_count[slot], smp);
                            solo = (solo_cost[slot] != 0) ? solo_cost[slot] : COST_SEED;
                            ratio = (smp * 100) / solo;
                            if (ratio < SLOW_MIN) ratio = SLOW_MIN;
                            if (ratio > SLOW_MAX) ratio = SLOW_MAX;
                            slowdown_pct = (slowdown_pct * 7 + ratio) / 8;
                            if (fabric_valid) fabric_ns = (fabric_ns * 7 + (x.ens >> 3)) / 8;
                            else fabric_ns = x.ens >> 3;
                            fabric_valid = 1'b1;
                        end else begin
                            ewma(solo_cost[slot], solo_count[slot], smp);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    initial clear_learning();

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_xfer     x;
        t_estimate e;
        t_estimate got;
        in_taken = s_tvalid && s_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_LIMIT_ONE:   lim_one = i_cfg_data;
                    REG_LIMIT_TWO:   lim_two = i_cfg_data;
                    REG_LIMIT_THREE: lim_three = i_cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.queue_ns = m_tdata[19:0];
                got.exec_ns = m_tdata[62:20];
                got.total_ns = m_tdata[106:63];
                if (expected_estimates.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_tdata);
                    errors++;
                end else begin
                    e = expected_estimates.pop_front();
                    if (got.queue_ns !== e.queue_ns) begin
                        $display("%0t: queue estimate expected %0d actual %0d",
                                 $time, e.queue_ns, got.queue_ns);
                        errors++;
                    end
                    if (got.exec_ns !== e.exec_ns) begin
                        $display("%0t: exec estimate expected %0d actual %0d",
                                 $time, e.exec_ns, got.exec_ns);
                        errors++;
                    end
                    if (got.total_ns !== e.total_ns) begin
                        $display("%0t: total estimate expected %0d actual %0d",
                                 $time, e.total_ns, got.total_ns);
                        errors++;
                    end
                end
            end
            if (in_taken) begin
                x.cmd = t_cmd'(s_tuser[1:0]);
                x.ch = s_tuser[2];
                x.bytes = s_tdata[39:0];
                x.qns = s_tdata[79:40];
                x.ens = s_tdata[119:80];
                x.ovl = s_tdata[120];
                predict_and_learn(x);
            end
        end
    end

    // input driver
    always @(negedge i_clk) begin
        t_xfer x;
        if (i_rst_n && (!s_tvalid || in_taken)) begin
            if (pending_xfers.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                x = pending_xfers.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= {x.ch, x.cmd};
                s_tdata <= {7'b0, x.ovl, x.ens, x.qns, x.bytes};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result acceptor, with a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [39:0] rand40();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [39:0] spread40();
        return rand40() >> $urandom_range(39, 0);
    endfunction

    function automatic t_xfer mk(t_cmd c, logic ch, logic [39:0] b, logic [39:0] q,
                                 logic [39:0] e, logic o);
        t_xfer x;
        x.cmd = c; x.ch = ch; x.bytes = b; x.qns = q; x.ens = e; x.ovl = o;
        return x;
    endfunction

    function automatic t_xfer noise_xfer();
        return mk(t_cmd'($urandom_range(3)), $urandom_range(1), rand40(), rand40(),
                  rand40(), $urandom_range(1));
    endfunction

    function automatic t_xfer observe_xfer(logic ch, logic ovl);
        logic [39:0] b, q, e;
        logic [63:0] guess;
        b = ($urandom_range(9) == 0) ? 40'd0 : spread40();
        q = ($urandom_range(7) == 0) ? 40'd0 : spread40();
        guess = 64'd200000 + ((64'(b) * 131072) >> 20);
        guess = guess * $urandom_range(150, 20) / 100;
        case ($urandom_range(5))
            0: e = 40'd0;
            1: e = spread40();
            default: e = (guess > MAX40) ? MAX40 : guess[39:0];
        endcase
        return mk(CMD_OBSERVE, ch, b, q, e, ovl);
    endfunction

    task automatic push_layers(int count);
        int n = 0;
        bit both;
        logic c;
        while (n < count) begin
            if ($urandom_range(9) == 0) begin
                pending_xfers.push_back(noise_xfer());
                n++;
            end else begin
                pending_xfers.push_back(mk(CMD_BEGIN, $urandom_range(1), rand40(), rand40(),
                                           rand40(), $urandom_range(1)));
                both = $urandom_range(1);
                c = $urandom_range(1);
                pending_xfers.push_back(mk(CMD_MISS, c, spread40(), rand40(), rand40(),
                                           $urandom_range(1)));
                n += 2;
                if (both) begin
                    pending_xfers.push_back(mk(CMD_MISS, !c, spread40(), rand40(), rand40(),
                                               $urandom_range(1)));
                    n++;
                end
                repeat ($urandom_range(6, 2)) begin
                    if ($urandom_range(3) == 0)
                        pending_xfers.push_back(mk(CMD_ESTIMATE, $urandom_range(1), spread40(),
                                                   rand40(), rand40(), $urandom_range(1)));
                    else
                        pending_xfers.push_back(observe_xfer($urandom_range(1),
                                                             both && $urandom_range(3) != 0));
                    n++;
                end
            end
        end
    endtask

    task automatic drain();
        while (pending_xfers.size() != 0 || s_tvalid || expected_estimates.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [1:0] idx, logic [39:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: size extremes, all commands, short body, clamps, dual mode
        pending_xfers.push_back(mk(CMD_ESTIMATE, 0, 40'd0, 0, 0, 0));
        pending_xfers.push_back(mk(CMD_ESTIMATE, 1, MAX40, MAX40, MAX40, 1));
        pending_xfers.push_back(mk(CMD_OBSERVE, 0, 40'd0, 40'd1, 40'd5000, 0));
        pending_xfers.push_back(mk(CMD_OBSERVE, 0, 40'd1000, MAX40, 40'd0, 0));
        pending_xfers.push_back(mk(CMD_OBSERVE, 1, 40'd100, 40'd7000, 40'd10, 0));
        pending_xfers.push_back(mk(CMD_OBSERVE, 1, 40'd100, 40'd0, 40'd190000, 0));
        pending_xfers.push_back(mk(CMD_OBSERVE, 0, MAX40, 40'd60000, 40'd300000, 0));
        pending_xfers.push_back(mk(CMD_OBSERVE, 0, 40'd8, 40'd60000, MAX40, 0));
        pending_xfers.push_back(mk(CMD_OBSERVE, 1, 40'd70000, 40'd40000, 40'd215000, 0));
        pending_xfers.push_back(mk(CMD_MISS, 0, 40'd5000, 0, 0, 0));
        pending_xfers.push_back(mk(CMD_ESTIMATE, 0, 40'd5000, 0, 0, 0));
        pending_xfers.push_back(mk(CMD_MISS, 1, 40'd2000000, 0, 0, 1));
        pending_xfers.push_back(mk(CMD_ESTIMATE, 1, 40'd2000000, 0, 0, 0));
        pending_xfers.push_back(mk(CMD_OBSERVE, 1, 40'd2000000, 40'd9000, 40'd2500000, 1));
        pending_xfers.push_back(mk(CMD_OBSERVE, 0, 40'd5000, 40'd9000, 40'd400000, 1));
        pending_xfers.push_back(mk(CMD_OBSERVE, 0, 40'd64, 40'd9000, MAX40, 1));
        pending_xfers.push_back(mk(CMD_OBSERVE, 1, 40'd300000, 40'd9000, 40'd230000, 1));
        pending_xfers.push_back(mk(CMD_ESTIMATE, 0, MAX40, 0, 0, 0));
        pending_xfers.push_back(mk(CMD_BEGIN, 1, MAX40, MAX40, MAX40, 1));
        pending_xfers.push_back(mk(CMD_ESTIMATE, 0, 40'd4096, 0, 0, 0));
        drain();

        push_layers(540);
        drain();

        write_limit(REG_LIMIT_ONE, 40'd1000);
        write_limit(REG_LIMIT_TWO, 40'd500);
        write_limit(REG_LIMIT_THREE, 40'h80_0000_0000);
        send_idle_pct = 83;
        recv_idle_pct = 33;
        push_layers(540);
        drain();

        write_limit(REG_LIMIT_ONE, 40'd0);
        write_limit(REG_LIMIT_TWO, MAX40);
        write_limit(REG_LIMIT_THREE, MAX40);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_layers(270);
        while (pending_xfers.size() > 200) @(posedge i_clk);
        @(negedge i_clk);
        hold_cycles <= 2000;
        drain();

        write_limit(REG_LIMIT_ONE, 40'd2048);
        write_limit(REG_LIMIT_TWO, 40'd2048);
        write_limit(REG_LIMIT_THREE, 40'd0);
        push_layers(270);
        drain();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
